[design/bmhqo_pkg.sv]
// ----------------------------------------------------------------------------
// bmhqo_pkg
// Shared types and codes of the binary min-heap queue order block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bmhqo_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int QUEUE_W      = 8;
  localparam int KEY_W        = 64;

  typedef struct packed {
    logic [QUEUE_W-1:0] queue;
    logic [KEY_W-1:0]   key;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    ACT_ADD = 1'b0,
    ACT_POP = 1'b1
  } action_t;

  // Operand choice of the shared key comparator
  typedef enum logic [0:0] {
    CMP_UP = 1'b0,   // held item key < parent key
    CMP_DN = 1'b1    // left child key < right child key
  } cmp_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP_RD,
    ST_POP_LAST,
    ST_DN_RD,
    ST_DN_CMP,
    ST_UP_RD,
    ST_UP_CMP,
    ST_RESULT
  } state_t;

endpackage

`default_nettype wire

[design/bmhqo_ram.sv]
// ----------------------------------------------------------------------------
// bmhqo_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bmhqo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

[design/bmhqo_cmp.sv]
// ----------------------------------------------------------------------------
// bmhqo_cmp
// Shared 64-bit key comparator with operand selection for sift-up and
// sift-down steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bmhqo_cmp import bmhqo_pkg::*; (
  input  wire cmp_sel_t sel,
  input  wire entry_t   item,
  input  wire entry_t   rd_a,
  input  wire entry_t   rd_b,
  output logic          lt
);

  logic [KEY_W-1:0] op_l;
  logic [KEY_W-1:0] op_r;

  always_comb begin
    unique case (sel)
      CMP_UP: begin
        op_l = item.key;
        op_r = rd_a.key;
      end
      CMP_DN: begin
        op_l = rd_a.key;
        op_r = rd_b.key;
      end
      default: begin
        op_l = rd_a.key;
        op_r = rd_b.key;
      end
    endcase
  end

  assign lt = (op_l < op_r);

endmodule

`default_nettype wire

[design/binary_min_heap_queue_order.sv]
// ----------------------------------------------------------------------------
// binary_min_heap_queue_order
// Min-heap of (queue number, 64-bit ordinal) entries reporting the queue
// with the smallest ordinal after every add or pop.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// while the heap is updated, and the item's single result shows on the out_
// ports for one cycle marked by out_valid, in the first cycle with busy low
// again, with no way for the receiver to hold it. A new item may be taken in
// that same cycle. Every heap level takes one registered read of the entry
// RAM and one step of the single key comparator with the write back. An add
// climbs levels until it reaches the root or a parent stops it. A pop's hole
// walks down levels; when it ends above a lone left child that child fills
// it and the pop is over, otherwise the last entry then climbs from the hole
// until it reaches the root or a parent stops it. A rejected add or an empty
// pop goes straight to the result.
`timescale 1ns / 1ps
`default_nettype none

module binary_min_heap_queue_order import bmhqo_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            in_action,
  input  wire logic [QUEUE_W-1:0]              in_queue_id,
  input  wire logic [KEY_W-1:0]                in_order_key,
  output logic                                 out_valid,
  output logic [1:0]                           out_status,
  output logic                                 out_min_valid,
  output logic [QUEUE_W-1:0]                   out_min_queue,
  output logic [KEY_W-1:0]                     out_min_key,
  output logic [$clog2(CAPACITY+1)-1:0]        out_entry_count
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int EXT_W = CNT_W + 1;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [IDX_W-1:0]     pos_r, pos_nxt;
  entry_t               item_r, item_nxt;
  status_t              status_r, status_nxt;
  entry_t               root_r;

  logic                 out_valid_r;
  status_t              out_status_r;
  logic                 out_min_valid_r;
  entry_t               out_min_r;
  logic [CNT_W-1:0]     out_count_r;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  entry_t               ram_wdata;
  logic [IDX_W-1:0]     ram_raddr_a;
  logic [IDX_W-1:0]     ram_raddr_b;
  entry_t               rd_a;
  entry_t               rd_b;
  cmp_sel_t             cmp_sel;
  logic                 cmp_lt;

  logic                 accept;
  logic [EXT_W-1:0]     count_ext;
  logic [EXT_W-1:0]     lc_ext;
  logic [EXT_W-1:0]     rc_ext;
  logic [IDX_W-1:0]     parent_idx;

  assign accept     = start && (state_r == ST_IDLE);
  assign count_ext  = EXT_W'(count_r);
  assign lc_ext     = EXT_W'({pos_r, 1'b1});
  assign rc_ext     = lc_ext + EXT_W'(1);
  assign parent_idx = IDX_W'((pos_r - IDX_W'(1)) >> 1);

  bmhqo_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  bmhqo_cmp u_cmp (
    .sel  (cmp_sel),
    .item (item_r),
    .rd_a (rd_a),
    .rd_b (rd_b),
    .lt   (cmp_lt)
  );

  // Next state and sequencer registers
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    pos_nxt    = pos_r;
    item_nxt   = item_r;
    status_nxt = status_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          status_nxt = STAT_DONE;
          if (action_t'(in_action) == ACT_ADD) begin
            if (count_r == CNT_W'(CAPACITY)) begin
              status_nxt = STAT_FULL;
              state_nxt  = ST_RESULT;
            end else begin
              item_nxt.queue = in_queue_id;
              item_nxt.key   = in_order_key;
              pos_nxt        = count_r[IDX_W-1:0];
              count_nxt      = count_r + CNT_W'(1);
              state_nxt      = ST_UP_RD;
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = STAT_EMPTY;
              state_nxt  = ST_RESULT;
            end else begin
              count_nxt = count_r - CNT_W'(1);
              state_nxt = ST_POP_RD;
            end
          end
        end
      end
      ST_POP_RD: begin
        state_nxt = ST_POP_LAST;
      end
      ST_POP_LAST: begin
        // hold the last entry; the hole starts at the root
        item_nxt  = rd_a;
        pos_nxt   = '0;
        state_nxt = ST_DN_RD;
      end
      ST_DN_RD: begin
        if (lc_ext > count_ext) begin
          state_nxt = ST_UP_RD;
        end else begin
          state_nxt = ST_DN_CMP;
        end
      end
      ST_DN_CMP: begin
        if (rc_ext > count_ext) begin
          state_nxt = ST_RESULT;
        end else if (cmp_lt) begin
          pos_nxt   = lc_ext[IDX_W-1:0];
          state_nxt = ST_DN_RD;
        end else begin
          pos_nxt   = rc_ext[IDX_W-1:0];
          state_nxt = ST_DN_RD;
        end
      end
      ST_UP_RD: begin
        if (pos_r == '0) begin
          state_nxt = ST_RESULT;
        end else begin
          state_nxt = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        if (cmp_lt) begin
          pos_nxt   = parent_idx;
          state_nxt = ST_UP_RD;
        end else begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // RAM and comparator control
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = pos_r;
    ram_wdata   = item_r;
    ram_raddr_a = lc_ext[IDX_W-1:0];
    ram_raddr_b = rc_ext[IDX_W-1:0];
    cmp_sel     = CMP_DN;
    unique case (state_r)
      ST_POP_RD: begin
        ram_raddr_a = count_r[IDX_W-1:0];
      end
      ST_DN_CMP: begin
        ram_we = 1'b1;
        if ((rc_ext > count_ext) || cmp_lt) begin
          ram_wdata = rd_a;
        end else begin
          ram_wdata = rd_b;
        end
      end
      ST_UP_RD: begin
        ram_raddr_a = parent_idx;
        ram_we      = (pos_r == '0);
      end
      ST_UP_CMP: begin
        cmp_sel = CMP_UP;
        ram_we  = 1'b1;
        if (cmp_lt) begin
          ram_wdata = rd_a;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= (state_r == ST_RESULT);
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    item_r   <= item_nxt;
    status_r <= status_nxt;
    // shadow the root so the result needs no extra read
    if (ram_we && (ram_waddr == '0)) begin
      root_r <= ram_wdata;
    end
    if (state_r == ST_RESULT) begin
      out_status_r    <= status_r;
      out_count_r     <= count_r;
      out_min_valid_r <= (count_r != '0);
      out_min_r       <= (count_r != '0) ? root_r : '0;
    end
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_min_valid   = out_min_valid_r;
  assign out_min_queue   = out_min_r.queue;
  assign out_min_key     = out_min_r.key;
  assign out_entry_count = out_count_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_strobe_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_RESULT))
    else $error("result strobe without result state");

  a_pop_decrements: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_action && (count_r != '0)) |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("pop did not drop the count");

  a_min_valid_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_min_valid_r == (out_count_r != '0)))
    else $error("min valid disagrees with count");
`endif

endmodule

`default_nettype wire

[tb/tb_binary_min_heap_queue_order.sv]
// ----------------------------------------------------------------------------
// tb_binary_min_heap_queue_order
// Self-checking bench for the min-heap queue order block: a local heap
// tracks every accepted add or pop and predicts the one result per item.
// Each result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_binary_min_heap_queue_order;
  import bmhqo_pkg::*;

  localparam int CAP         = CAPACITY_DEF;
  localparam int CNT_W       = $clog2(CAP + 1);
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_TAIL  = 40;

  typedef struct packed {
    status_t            status;
    logic               min_valid;
    logic [QUEUE_W-1:0] min_queue;
    logic [KEY_W-1:0]   min_key;
    logic [CNT_W-1:0]   count;
  } heap_result_t;

  logic                 clk;
  logic                 rst_n        = 1'b0;
  logic                 start        = 1'b0;
  logic                 in_action    = 1'b0;
  logic [QUEUE_W-1:0]   in_queue_id  = '0;
  logic [KEY_W-1:0]     in_order_key = '0;
  logic                 busy;
  logic                 out_valid;
  logic [1:0]           out_status;
  logic                 out_min_valid;
  logic [QUEUE_W-1:0]   out_min_queue;
  logic [KEY_W-1:0]     out_min_key;
  logic [CNT_W-1:0]     out_entry_count;

  // Tracked heap contents
  logic [QUEUE_W-1:0]   heap_queue [CAP];
  logic [KEY_W-1:0]     heap_key   [CAP];
  int                   heap_held;

  heap_result_t         expected_minima [$];
  heap_result_t         oldest_minimum;
  int                   idle_pct;
  int                   mismatch_total;
  int                   stall_cycles;
  int                   results_seen;
  int                   add_count, pop_count, full_count, empty_count, peak_held;

  binary_min_heap_queue_order u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_queue_id     (in_queue_id),
    .in_order_key    (in_order_key),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_min_valid   (out_min_valid),
    .out_min_queue   (out_min_queue),
    .out_min_key     (out_min_key),
    .out_entry_count (out_entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Heap tracking
  // --------------------------------------------------------------------------
  function automatic void sift_into(int pos, logic [QUEUE_W-1:0] q, logic [KEY_W-1:0] k);
    int parent;
    while (pos != 0) begin
      parent = (pos - 1) >> 1;
      if (heap_key[parent] <= k) break;
      heap_queue[pos] = heap_queue[parent];
      heap_key[pos]   = heap_key[parent];
      pos = parent;
    end
    heap_queue[pos] = q;
    heap_key[pos]   = k;
  endfunction

  function automatic void take_root();
    int old_held;
    int hole;
    int lc;
    int rc;
    old_held  = heap_held;
    hole      = 0;
    heap_held = old_held - 1;
    while (1) begin
      lc = 2 * hole + 1;
      if (lc >= old_held) break;
      rc = lc + 1;
      // Left child is the last entry: it fills the hole and the pop is over
      if (rc >= old_held) begin
        heap_queue[hole] = heap_queue[lc];
        heap_key[hole]   = heap_key[lc];
        return;
      end
      // Take the right child on equal keys
      if (heap_key[lc] < heap_key[rc]) begin
        heap_queue[hole] = heap_queue[lc];
        heap_key[hole]   = heap_key[lc];
        hole = lc;
      end else begin
        heap_queue[hole] = heap_queue[rc];
        heap_key[hole]   = heap_key[rc];
        hole = rc;
      end
    end
    sift_into(hole, heap_queue[old_held - 1], heap_key[old_held - 1]);
  endfunction

  function automatic heap_result_t next_minimum(action_t act, logic [QUEUE_W-1:0] q,
                                                logic [KEY_W-1:0] k);
    heap_result_t r;
    r = '0;
    r.status = STAT_DONE;
    if (act == ACT_ADD) begin
      add_count++;
      if (heap_held >= CAP) begin
        r.status = STAT_FULL;
        full_count++;
      end else begin
        heap_held++;
        sift_into(heap_held - 1, q, k);
      end
    end else begin
      pop_count++;
      if (heap_held == 0) begin
        r.status = STAT_EMPTY;
        empty_count++;
      end else begin
        take_root();
      end
    end
    if (heap_held != 0) begin
      r.min_valid = 1'b1;
      r.min_queue = heap_queue[0];
      r.min_key   = heap_key[0];
    end
    r.count = CNT_W'(heap_held);
    if (heap_held > peak_held) peak_held = heap_held;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------
  task automatic send_item(action_t act, logic [QUEUE_W-1:0] q, logic [KEY_W-1:0] k);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    in_action    <= act;
    in_queue_id  <= q;
    in_order_key <= k;
    do @(posedge clk); while (busy);
    expected_minima.push_back(next_minimum(act, q, k));
  endtask

  // Hold the sender until every outstanding result is back
  task automatic wait_results_in();
    start <= 1'b0;
    do @(posedge clk); while (expected_minima.size() != 0);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(3))
      0:       return {$urandom, $urandom};
      1:       return KEY_W'($urandom_range(7));
      2:       return 64'hFFFF_FFFF_FFFF_FFF8 | KEY_W'($urandom_range(7));
      default: return {30'd0, 2'($urandom_range(3)), $urandom};
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_edges_and_ties();
    send_item(ACT_POP, 8'h00, 64'd0);                   // pop on empty heap
    send_item(ACT_ADD, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(ACT_ADD, 8'h00, 64'd0);                   // new minimum
    send_item(ACT_ADD, 8'hAA, 64'd0);                   // equal key stays below
    send_item(ACT_ADD, 8'h55, 64'h8000_0000_0000_0000);
    send_item(ACT_ADD, 8'h01, 64'h7FFF_FFFF_FFFF_FFFF);
    send_item(ACT_ADD, 8'h02, 64'd0);
    repeat (6) send_item(ACT_POP, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(ACT_POP, 8'h33, 64'd9);                   // empty again
    send_item(ACT_ADD, 8'h5A, 64'd5);
    send_item(ACT_ADD, 8'hA5, 64'd5);
    send_item(ACT_ADD, 8'h0F, 64'd5);
    send_item(ACT_ADD, 8'hF0, 64'd5);
    repeat (4) send_item(ACT_POP, 8'h00, 64'd0);
    wait_results_in();
  endtask

  task automatic test_fill_and_drain();
    repeat (CAP) send_item(ACT_ADD, 8'($urandom_range(255)), pick_key());
    repeat (3) send_item(ACT_ADD, 8'($urandom_range(255)), pick_key());   // refused
    repeat (CAP + 3) send_item(ACT_POP, 8'($urandom_range(255)), pick_key());
    wait_results_in();
  endtask

  task automatic test_random_mix(int n_items);
    int      add_pct;
    action_t act;
    for (int i = 0; i < n_items; i++) begin
      // Sweep the fill level up and down in long swings
      add_pct = ((i / 150) % 2 == 0) ? 72 : 28;
      if (heap_held == 0) add_pct = 90;
      if (heap_held == CAP) add_pct = 10;
      act = ($urandom_range(99) < add_pct) ? ACT_ADD : ACT_POP;
      send_item(act, 8'($urandom_range(255)), pick_key());
      if ($urandom_range(199) == 0) wait_results_in();
    end
    wait_results_in();
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_seen++;
      if (expected_minima.size() == 0) begin
        $error("result with no item outstanding");
        mismatch_total++;
      end else begin
        oldest_minimum = expected_minima.pop_front();
        if (out_status !== oldest_minimum.status) begin
          $error("out_status: expected %0d, got %0d", oldest_minimum.status, out_status);
          mismatch_total++;
        end
        if (out_min_valid !== oldest_minimum.min_valid) begin
          $error("out_min_valid: expected %0d, got %0d", oldest_minimum.min_valid,
                 out_min_valid);
          mismatch_total++;
        end
        if (out_min_queue !== oldest_minimum.min_queue) begin
          $error("out_min_queue: expected %0d, got %0d", oldest_minimum.min_queue,
                 out_min_queue);
          mismatch_total++;
        end
        if (out_min_key !== oldest_minimum.min_key) begin
          $error("out_min_key: expected %h, got %h", oldest_minimum.min_key, out_min_key);
          mismatch_total++;
        end
        if (out_entry_count !== oldest_minimum.count) begin
          $error("out_entry_count: expected %0d, got %0d", oldest_minimum.count,
                 out_entry_count);
          mismatch_total++;
        end
      end
    end
  end

  // Watchdog on cycles with no item accepted
  always @(posedge clk) begin
    if (!rst_n || (start && !busy)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: nothing moved for %0d cycles", STALL_LIMIT);
        $display("binary_min_heap_queue_order regression: fail");
        $finish;
      end
    end
  end

  initial begin
    heap_held      = 0;
    idle_pct       = 0;
    mismatch_total = 0;
    stall_cycles   = 0;
    results_seen   = 0;
    add_count      = 0;
    pop_count      = 0;
    full_count     = 0;
    empty_count    = 0;
    peak_held      = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct = 17;
    test_edges_and_ties();
    test_fill_and_drain();
    // Back-to-back items, no gaps
    idle_pct = 0;
    test_fill_and_drain();
    test_random_mix(300);
    idle_pct = 17;
    test_random_mix(1300);

    wait_results_in();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (expected_minima.size() != 0) begin
      $error("%0d results never arrived", expected_minima.size());
      mismatch_total++;
    end
    $display("covered %0d adds (%0d refused on full) and %0d pops (%0d on empty),",
             add_count, full_count, pop_count, empty_count);
    $display("%0d results checked, heap filled up to %0d entries", results_seen, peak_held);
    if (mismatch_total == 0) begin
      $display("binary_min_heap_queue_order regression: pass");
    end else begin
      $display("binary_min_heap_queue_order regression: fail");
    end
    $finish;
  end

endmodule
